>>> rtl/elt_pkg.sv
// ----------------------------------------------------------------------------
// Entity location table package
// Sizes, request and status codes, and shared types for the table core.
// ----------------------------------------------------------------------------
package elt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ID_WIDTH    = 16;
  localparam int COORD_WIDTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Request function codes
  localparam logic [2:0] FN_QUERY  = 3'd0;
  localparam logic [2:0] FN_MOVE   = 3'd1;
  localparam logic [2:0] FN_REMOVE = 3'd2;
  localparam logic [2:0] FN_LOCATE = 3'd3;
  localparam logic [2:0] FN_VIEW   = 3'd4;
  localparam logic [2:0] FN_CLEAR  = 3'd5;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_MISS  = 2'd1;
  localparam logic [1:0] STAT_TAKEN = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef logic [ID_WIDTH-1:0]           ent_t;
  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One table slot
  typedef struct packed {
    ent_t   entity;
    coord_t x;
    coord_t y;
  } slot_t;

  // Latched request
  typedef struct packed {
    logic [2:0] func;
    ent_t       entity;
    coord_t     x0;
    coord_t     y0;
    coord_t     x1;
    coord_t     y1;
  } req_t;

  // Compare flags of one slot against the request
  typedef struct packed {
    logic ent_eq;
    logic loc_eq;
    logic in_rect;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

>>> rtl/elt_if.sv
// ----------------------------------------------------------------------------
// Entity location table channels
// Valid/ready request and result channels with their payloads.
// ----------------------------------------------------------------------------
interface elt_in_if import elt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] func;
  ent_t       entity;
  coord_t     coord_x;
  coord_t     coord_y;
  coord_t     corner_x;
  coord_t     corner_y;

  modport source (output valid, func, entity, coord_x, coord_y, corner_x, corner_y,
                  input ready);
  modport sink   (input valid, func, entity, coord_x, coord_y, corner_x, corner_y,
                  output ready);
endinterface

interface elt_out_if import elt_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  ent_t       found_entity;
  coord_t     found_x;
  coord_t     found_y;
  logic       last;

  modport source (output valid, status, found_entity, found_x, found_y, last,
                  input ready);
  modport sink   (input valid, status, found_entity, found_x, found_y, last,
                  output ready);
endinterface

>>> rtl/elt_match.sv
// ----------------------------------------------------------------------------
// Entity location table slot compare
// Compares one slot read from the table against the current request.
// ----------------------------------------------------------------------------
module elt_match import elt_pkg::*; (
  input  slot_t  slot,
  input  req_t   req,
  output match_t hit
);

  // Flag entity, exact location and inclusive rectangle hits (signed order)
  assign hit.ent_eq  = (slot.entity == req.entity);
  assign hit.loc_eq  = (slot.x == req.x0) && (slot.y == req.y0);
  assign hit.in_rect = ($signed(slot.x) >= $signed(req.x0)) &&
                       ($signed(slot.x) <= $signed(req.x1)) &&
                       ($signed(slot.y) >= $signed(req.y0)) &&
                       ($signed(slot.y) <= $signed(req.y1));

endmodule

>>> rtl/entity_location_table_core.sv
// ----------------------------------------------------------------------------
// Entity location table core
// Ordered table of (entity, x, y) slots held in one synchronous memory.
// ----------------------------------------------------------------------------
// The block takes one request at a time. Each request (but clear) scans the
// filled slots one per cycle, while the result register is free, through the
// single read port of the slot memory, then finishes; clear goes straight to
// the finish state. A view stalls its scan while a listed pair waits on a full
// result register. Remove closes the gap during the same scan, writing each
// later slot one place down. Func codes 6 and 7 are dropped with no result.
// ----------------------------------------------------------------------------
module entity_location_table_core import elt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  elt_in_if.sink       in_ch,
  elt_out_if.source    out_ch
);

  typedef struct packed {
    logic [1:0] status;
    ent_t       entity;
    coord_t     x;
    coord_t     y;
    logic       last;
  } result_t;

  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic [IDX_W-1:0]   p_idx_r, p_idx_nxt;
  logic               ent_hit_r, ent_hit_nxt;
  logic [IDX_W-1:0]   ent_idx_r, ent_idx_nxt;
  slot_t              ent_slot_r, ent_slot_nxt;
  logic               loc_hit_r, loc_hit_nxt;
  ent_t               loc_ent_r, loc_ent_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  slot_t              pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_r, out_nxt;

  slot_t              slot_mem [TABLE_DEPTH];
  slot_t              rd_data_r;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_t              wr_data;

  logic               adv;
  logic               scan_done;
  match_t             hit;

  // Result register frees up when empty or taken this cycle
  assign adv       = !out_valid_r || out_ch.ready;
  assign scan_done = (rd_idx_r == fill_r) && !p_valid_r;

  elt_match u_match (
    .slot (rd_data_r),
    .req  (req_r),
    .hit  (hit)
  );

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= slot_mem[rd_addr];
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == FN_CLEAR) begin
            state_nxt = ST_FINISH;
          end else if (in_ch.func < FN_CLEAR) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (adv && scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (adv) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    req_nxt        = req_r;
    fill_nxt       = fill_r;
    rd_idx_nxt     = rd_idx_r;
    p_valid_nxt    = p_valid_r;
    p_idx_nxt      = p_idx_r;
    ent_hit_nxt    = ent_hit_r;
    ent_idx_nxt    = ent_idx_r;
    ent_slot_nxt   = ent_slot_r;
    loc_hit_nxt    = loc_hit_r;
    loc_ent_nxt    = loc_ent_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    rd_en          = 1'b0;
    rd_addr        = rd_idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = p_idx_r;
    wr_data        = rd_data_r;

    // Drop the result once taken
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        // Latch the request and clear the scan flags
        if (in_ch.valid) begin
          req_nxt.func   = in_ch.func;
          req_nxt.entity = in_ch.entity;
          req_nxt.x0     = in_ch.coord_x;
          req_nxt.y0     = in_ch.coord_y;
          req_nxt.x1     = in_ch.corner_x;
          req_nxt.y1     = in_ch.corner_y;
          rd_idx_nxt     = '0;
          p_valid_nxt    = 1'b0;
          ent_hit_nxt    = 1'b0;
          loc_hit_nxt    = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end

      ST_SCAN: begin
        if (adv) begin
          // Issue the next slot read
          if (rd_idx_r != fill_r) begin
            rd_en       = 1'b1;
            p_valid_nxt = 1'b1;
            p_idx_nxt   = rd_idx_r[IDX_W-1:0];
            rd_idx_nxt  = rd_idx_r + CNT_W'(1);
          end else begin
            p_valid_nxt = 1'b0;
          end

          // Evaluate the slot whose read was issued before
          if (p_valid_r) begin
            if (req_r.func == FN_REMOVE && ent_hit_r) begin
              wr_en   = 1'b1;
              wr_addr = p_idx_r - IDX_W'(1);
              wr_data = rd_data_r;
            end
            if (hit.ent_eq && !ent_hit_r) begin
              ent_hit_nxt  = 1'b1;
              ent_idx_nxt  = p_idx_r;
              ent_slot_nxt = rd_data_r;
            end
            if (hit.loc_eq && !loc_hit_r) begin
              loc_hit_nxt = 1'b1;
              loc_ent_nxt = rd_data_r.entity;
            end
            // Hold one listed pair back so the final one can carry last
            if (req_r.func == FN_VIEW && hit.in_rect) begin
              if (pend_valid_r) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = STAT_OK;
                out_nxt.entity = pend_r.entity;
                out_nxt.x      = pend_r.x;
                out_nxt.y      = pend_r.y;
                out_nxt.last   = 1'b0;
              end
              pend_nxt       = rd_data_r;
              pend_valid_nxt = 1'b1;
            end
          end
        end
      end

      ST_FINISH: begin
        if (adv) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = STAT_MISS;
          out_nxt.entity = '0;
          out_nxt.x      = '0;
          out_nxt.y      = '0;
          out_nxt.last   = 1'b1;
          unique case (req_r.func)
            FN_QUERY: begin
              if (loc_hit_r) begin
                out_nxt.status = STAT_OK;
                out_nxt.entity = loc_ent_r;
              end
            end
            FN_MOVE: begin
              if (req_r.entity != '0) begin
                if (loc_hit_r && loc_ent_r != req_r.entity) begin
                  out_nxt.status = STAT_TAKEN;
                end else if (!ent_hit_r) begin
                  if (fill_r == CNT_W'(TABLE_DEPTH)) begin
                    out_nxt.status = STAT_FULL;
                  end else begin
                    // Append a new slot
                    wr_en          = 1'b1;
                    wr_addr        = fill_r[IDX_W-1:0];
                    wr_data.entity = req_r.entity;
                    wr_data.x      = req_r.x0;
                    wr_data.y      = req_r.y0;
                    fill_nxt       = fill_r + CNT_W'(1);
                    out_nxt.status = STAT_OK;
                  end
                end else begin
                  // Rewrite the entity's slot in place
                  wr_en          = 1'b1;
                  wr_addr        = ent_idx_r;
                  wr_data.entity = req_r.entity;
                  wr_data.x      = req_r.x0;
                  wr_data.y      = req_r.y0;
                  out_nxt.status = STAT_OK;
                end
              end
            end
            FN_REMOVE: begin
              if (ent_hit_r) begin
                fill_nxt       = fill_r - CNT_W'(1);
                out_nxt.status = STAT_OK;
              end
            end
            FN_LOCATE: begin
              if (ent_hit_r) begin
                out_nxt.status = STAT_OK;
                out_nxt.entity = ent_slot_r.entity;
                out_nxt.x      = ent_slot_r.x;
                out_nxt.y      = ent_slot_r.y;
              end
            end
            FN_VIEW: begin
              if (pend_valid_r) begin
                out_nxt.status = STAT_OK;
                out_nxt.entity = pend_r.entity;
                out_nxt.x      = pend_r.x;
                out_nxt.y      = pend_r.y;
              end
            end
            FN_CLEAR: begin
              fill_nxt       = '0;
              out_nxt.status = STAT_OK;
            end
            default: begin
              out_nxt.status = STAT_MISS;
            end
          endcase
        end
      end

      default: begin
        out_valid_nxt = out_valid_r && !out_ch.ready;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      rd_idx_r     <= '0;
      p_valid_r    <= 1'b0;
      ent_hit_r    <= 1'b0;
      loc_hit_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      rd_idx_r     <= rd_idx_nxt;
      p_valid_r    <= p_valid_nxt;
      ent_hit_r    <= ent_hit_nxt;
      loc_hit_r    <= loc_hit_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    p_idx_r    <= p_idx_nxt;
    ent_idx_r  <= ent_idx_nxt;
    ent_slot_r <= ent_slot_nxt;
    loc_ent_r  <= loc_ent_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  // Channel outputs
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_r.status;
  assign out_ch.found_entity = out_r.entity;
  assign out_ch.found_x      = out_r.x;
  assign out_ch.found_y      = out_r.y;
  assign out_ch.last         = out_r.last;

endmodule
